// ----- src/bsbrl_pkg.sv -----
package bsbrl_pkg;

    localparam int unsigned MAX_REGION_BYTES = 4096;
    localparam int unsigned RUN_CAP_RAW      = MAX_REGION_BYTES * 8;
    localparam int unsigned RUN_CAP_INT      = (RUN_CAP_RAW > 65535) ? 65535 : RUN_CAP_RAW;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 3;
    localparam int unsigned TCNT_W  = 4;
    localparam int unsigned RUN_W   = 16;

    localparam logic [RUN_W-1:0]  RUN_CAP     = RUN_W'(RUN_CAP_INT);
    localparam logic [TCNT_W-1:0] BYTE_BITS   = TCNT_W'(BYTE_W);
    localparam logic [BYTE_W-1:0] BYTE_MASK   = 8'hFF;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [INDEX_W-1:0] bit_index_t;
    typedef logic [TCNT_W-1:0]  tcnt_t;
    typedef logic [RUN_W-1:0]   run_len_t;

    // consecutive ones from bit 0 upward
    function automatic tcnt_t trailing_ones(input byte_t x);
        tcnt_t n;
        logic  stop;
        n    = '0;
        stop = 1'b0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (!stop && x[i])
            begin
                n = n + tcnt_t'(1);
            end
            else
            begin
                stop = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ----- src/bsbrl_if.sv -----
interface bsbrl_in_if
    import bsbrl_pkg::*;
();
    logic       valid;
    logic       ready;
    byte_t      map_byte;
    bit_index_t start_bit;
    logic       first_of_region;
    logic       last_of_region;

    modport source (output valid, output map_byte, output start_bit,
                    output first_of_region, output last_of_region, input ready);
    modport sink   (input valid, input map_byte, input start_bit,
                    input first_of_region, input last_of_region, output ready);
endinterface

interface bsbrl_out_if
    import bsbrl_pkg::*;
();
    logic     valid;
    logic     ready;
    run_len_t run_length;
    logic     run_of_ones;

    modport source (output valid, output run_length, output run_of_ones, input ready);
    modport sink   (input valid, input run_length, input run_of_ones, output ready);
endinterface

// ----- src/bitmap_similar_bit_run_length.sv -----
// Bit run length counter over a streamed bitmap region.
//
// item   : one bitmap byte per transfer (bit 0 first), with start_bit,
//          first_of_region and last_of_region marks.
// result : run_length and run_of_ones, one transfer per finished run.
//
// A first_of_region byte opens a run at start_bit; the run closes on the
// byte holding the first differing bit, or on the last_of_region byte.
// Bytes outside an open run produce nothing. run_length saturates at RUN_CAP.
//
// Throughput: one item per cycle while item.ready is high (see Stall).
// Each byte costs an 8-bit trailing-ones count and a 16-bit saturating
// add, done between the input ports and the result register.
// Latency: a result is valid in the cycle after the transfer of the closing
// byte.
// Reset clears the open run and empties the result register.
// Stall: a result not taken is held; item.ready stays high as long as the
// result register is empty or is taken in the same cycle.
module bitmap_similar_bit_run_length
    import bsbrl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bsbrl_in_if.sink      item,
    bsbrl_out_if.source   result
);

    logic     run_polarity_reg, run_polarity_next;
    run_len_t run_count_reg,    run_count_next;
    logic     run_open_reg,     run_open_next;
    logic     res_valid_reg,    res_valid_next;
    run_len_t run_length_reg,   run_length_next;
    logic     run_of_ones_reg,  run_of_ones_next;

    logic            accept;
    logic            pol;
    byte_t           same;
    tcnt_t           t;
    tcnt_t           limit;
    run_len_t        base;
    logic [RUN_W:0]  sum;
    run_len_t        sat;
    logic            active;
    logic            ended;

    assign item.ready = !res_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        pol   = item.first_of_region ? item.map_byte[item.start_bit] : run_polarity_reg;
        same  = pol ? item.map_byte : (~item.map_byte & BYTE_MASK);
        if (item.first_of_region)
        begin
            same  = same >> item.start_bit;
            limit = BYTE_BITS - tcnt_t'(item.start_bit);
            base  = '0;
        end
        else
        begin
            limit = BYTE_BITS;
            base  = run_count_reg;
        end
        t      = trailing_ones(same);
        sum    = {1'b0, base} + (RUN_W+1)'(t);
        sat    = (sum > {1'b0, RUN_CAP}) ? RUN_CAP : sum[RUN_W-1:0];
        active = item.first_of_region || run_open_reg;
        ended  = (t < limit) || item.last_of_region;
    end

    always_comb
    begin
        run_polarity_next = run_polarity_reg;
        run_count_next    = run_count_reg;
        run_open_next     = run_open_reg;
        run_length_next   = run_length_reg;
        run_of_ones_next  = run_of_ones_reg;
        res_valid_next    = res_valid_reg && !result.ready;
        if (accept && active)
        begin
            run_polarity_next = pol;
            run_count_next    = sat;
            run_open_next     = !ended;
            if (ended)
            begin
                res_valid_next   = 1'b1;
                run_length_next  = sat;
                run_of_ones_next = pol;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_polarity_reg <= 1'b0;
            run_count_reg    <= '0;
            run_open_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            run_polarity_reg <= run_polarity_next;
            run_count_reg    <= run_count_next;
            run_open_reg     <= run_open_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_length_reg  <= run_length_next;
        run_of_ones_reg <= run_of_ones_next;
    end

    assign result.valid       = res_valid_reg;
    assign result.run_length  = run_length_reg;
    assign result.run_of_ones = run_of_ones_reg;

endmodule

// ----- src/bsbrl_checker.sv -----
module bsbrl_checker
    import bsbrl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_ready,
    input  byte_t      map_byte,
    input  bit_index_t start_bit,
    input  logic       first_of_region,
    input  logic       last_of_region,
    input  logic       res_valid,
    input  logic       res_ready,
    input  run_len_t   run_length,
    input  logic       run_of_ones
);

    logic item_xfer;
    assign item_xfer = item_valid && item_ready;

    // held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(run_length) && $stable(run_of_ones))
        else $error("result changed while stalled");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> run_length != '0 && run_length <= RUN_CAP)
        else $error("run_length out of range");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> item_ready)
        else $error("item stalled with empty result register");

    // single byte region always closes at once, polarity from the start bit
    a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && first_of_region && last_of_region |=>
            res_valid && run_of_ones == $past(map_byte[start_bit]))
        else $error("single byte region result missing or wrong polarity");

endmodule

bind bitmap_similar_bit_run_length bsbrl_checker u_bsbrl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .map_byte        (item.map_byte),
    .start_bit       (item.start_bit),
    .first_of_region (item.first_of_region),
    .last_of_region  (item.last_of_region),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .run_length      (result.run_length),
    .run_of_ones     (result.run_of_ones)
);

// ----- bench/run_length_checker.sv -----
module run_length_checker
    import bsbrl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    bsbrl_in_if   item_bus,
    bsbrl_out_if  result_bus,
    output int    mismatches,
    output int    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        run_len_t run_length;
        logic     run_of_ones;
    } run_result_t;

    run_result_t expected_runs[$];

    logic     run_pol;
    run_len_t run_cnt;
    logic     run_active;
    int       errs = 0;
    int       waiting = 0;

    assign mismatches  = errs;
    assign outstanding = waiting;

    function automatic tcnt_t count_low_ones(input byte_t v);
        tcnt_t n;
        logic  hit;
        n   = '0;
        hit = 1'b1;
        for (int i = 0; i < BYTE_W; i++)
        begin
            hit = hit & v[i];
            if (hit)
            begin
                n = n + tcnt_t'(1);
            end
        end
        return n;
    endfunction

    function automatic run_len_t add_capped(input run_len_t acc, input tcnt_t t);
        logic [RUN_W:0] sum;
        sum = {1'b0, acc} + (RUN_W + 1)'(t);
        return (sum > {1'b0, RUN_CAP}) ? RUN_CAP : sum[RUN_W-1:0];
    endfunction

    task automatic track_byte(input byte_t b, input bit_index_t s,
                              input logic first, input logic last);
        byte_t       same;
        tcnt_t       t;
        tcnt_t       room;
        logic        counted;
        logic        closed;
        run_result_t r;
        counted = 1'b0;
        closed  = 1'b0;
        if (first)
        begin
            run_pol = b[s];
            same    = run_pol ? b : ~b;
            t       = count_low_ones(same >> s);
            run_cnt = add_capped('0, t);
            room    = BYTE_BITS - tcnt_t'(s);
            closed  = (t < room) || last;
            counted = 1'b1;
        end
        else if (run_active)
        begin
            same    = run_pol ? b : ~b;
            t       = count_low_ones(same);
            run_cnt = add_capped(run_cnt, t);
            closed  = (t < BYTE_BITS) || last;
            counted = 1'b1;
        end
        if (counted)
        begin
            run_active = !closed;
            if (closed)
            begin
                r.run_length  = run_cnt;
                r.run_of_ones = run_pol;
                expected_runs.push_back(r);
            end
        end
    endtask

    task automatic check_result();
        run_result_t want;
        if (expected_runs.size() == 0)
        begin
            $error("unexpected result: run_length %0d run_of_ones %0d",
                   result_bus.run_length, result_bus.run_of_ones);
            errs++;
        end
        else
        begin
            want = expected_runs.pop_front();
            if (result_bus.run_length !== want.run_length)
            begin
                $error("run_length: expected %0d, actual %0d",
                       want.run_length, result_bus.run_length);
                errs++;
            end
            if (result_bus.run_of_ones !== want.run_of_ones)
            begin
                $error("run_of_ones: expected %0d, actual %0d",
                       want.run_of_ones, result_bus.run_of_ones);
                errs++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_pol    = 1'b0;
            run_cnt    = '0;
            run_active = 1'b0;
            expected_runs.delete();
            waiting    = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                check_result();
            end
            if (item_bus.valid && item_bus.ready)
            begin
                track_byte(item_bus.map_byte, item_bus.start_bit,
                           item_bus.first_of_region, item_bus.last_of_region);
            end
            waiting = expected_runs.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
module testbench;
    import bsbrl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic src_idle = 1'b1;
    logic snk_idle = 1'b1;
    int   cycle_count = 0;
    int   mismatches;
    int   outstanding;
    int   sent = 0;

    bsbrl_in_if  item_bus();
    bsbrl_out_if result_bus();

    bitmap_similar_bit_run_length uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    run_length_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_bus    (item_bus),
        .result_bus  (result_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input byte_t b, input bit_index_t s,
                             input logic first, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            item_bus.valid           = 1'b0;
            item_bus.map_byte        = byte_t'($urandom);
            item_bus.start_bit       = bit_index_t'($urandom);
            item_bus.first_of_region = 1'($urandom);
            item_bus.last_of_region  = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        item_bus.map_byte        = b;
        item_bus.start_bit       = s;
        item_bus.first_of_region = first;
        item_bus.last_of_region  = last;
        item_bus.valid           = 1'b1;
        do @(posedge clk); while (!item_bus.ready);
        @(negedge clk);
        sent++;
    endtask

    // bytes that keep a run of polarity pol going, break it, or are random
    function automatic byte_t shaped_byte(input logic pol);
        byte_t v;
        int    k;
        case ($urandom_range(0, 3))
            0: v = pol ? 8'hFF : 8'h00;
            1:
            begin
                k = $urandom_range(0, 7);
                v = byte_t'($urandom);
                for (int i = 0; i < 8; i++)
                begin
                    if (i < k) v[i] = pol;
                    else if (i == k) v[i] = ~pol;
                end
            end
            default: v = byte_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_region();
        int         len;
        logic       pol;
        logic       broken;
        bit_index_t s;
        byte_t      b;
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        pol    = 1'($urandom);
        s      = bit_index_t'($urandom);
        broken = ($urandom_range(0, 11) == 0);
        for (int i = 0; i < len; i++)
        begin
            b = shaped_byte(pol);
            if (i == 0)
            begin
                for (int j = 0; j < 8; j++)
                begin
                    if (j >= s && $urandom_range(0, 2) != 0) b[j] = pol;
                end
            end
            send_byte(b, s, i == 0, (i == len - 1) && !broken);
        end
    endtask

    initial
    begin
        int stall;
        result_bus.ready = 1'b0;
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                result_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_bus.ready = 1'b1;
            do @(posedge clk); while (!result_bus.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int mode;
        item_bus.valid           = 1'b0;
        item_bus.map_byte        = '0;
        item_bus.start_bit       = '0;
        item_bus.first_of_region = 1'b0;
        item_bus.last_of_region  = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed
        send_byte(8'h00, 3'd0, 1'b1, 1'b1);
        send_byte(8'hFF, 3'd7, 1'b1, 1'b1);
        send_byte(8'h80, 3'd7, 1'b1, 1'b1);
        send_byte(8'h0F, 3'd0, 1'b1, 1'b0);
        send_byte(8'hF0, 3'd4, 1'b1, 1'b0);
        send_byte(8'hFF, 3'd2, 1'b0, 1'b0);
        send_byte(8'h03, 3'd5, 1'b0, 1'b0);
        send_byte(8'h55, 3'd1, 1'b0, 1'b0);
        send_byte(8'hAA, 3'd6, 1'b0, 1'b1);
        send_byte(8'h00, 3'd0, 1'b1, 1'b0);
        send_byte(8'hAA, 3'd1, 1'b1, 1'b0);
        send_byte(8'hFF, 3'd3, 1'b1, 1'b0);
        send_byte(8'hFF, 3'd0, 1'b0, 1'b1);
        send_byte(8'h12, 3'd4, 1'b0, 1'b1);
        send_byte(8'h7F, 3'd7, 1'b1, 1'b0);
        send_byte(8'h00, 3'd0, 1'b0, 1'b0);
        send_byte(8'h01, 3'd0, 1'b0, 1'b0);

        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 100 < 8)
            begin
                mode     = $urandom_range(0, 3);
                src_idle = mode[0];
                snk_idle = mode[1];
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_byte(byte_t'($urandom), bit_index_t'($urandom), 1'b0, 1'($urandom));
            end
            else
            begin
                send_region();
            end
        end
        item_bus.valid = 1'b0;

        while (outstanding != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- bitmap_similar_bit_run_length.f -----
src/bsbrl_pkg.sv
src/bsbrl_if.sv
src/bitmap_similar_bit_run_length.sv
src/bsbrl_checker.sv
bench/run_length_checker.sv
bench/testbench.sv
